[src/twsh_pkg.sv]
// ----------------------------------------------------------------------------
// twsh_pkg
// shared constants, datapath command codes and the command struct used by
// the controller and the datapath of the two-lane word sequence hash
// ----------------------------------------------------------------------------
package twsh_pkg;

    localparam int WORD_W = 64;
    localparam int HALF_W = WORD_W / 2;
    localparam int CNT_W  = 32;

    localparam logic [WORD_W-1:0] SEED_LANE0 = 64'h16f1_1fe8_9b0d_677c;
    localparam logic [WORD_W-1:0] SEED_LANE1 = 64'hb480_a793_d8e6_c86c;
    localparam logic [WORD_W-1:0] DIFF_MULT  = 64'h6eed_0e9d_a4d9_4a4f;

    // operand pair whose xor is loaded into the diffusion register on a load
    typedef enum logic [2:0] {
        LD_L0_WORD,
        LD_L1_WORD,
        LD_L0_CNT,
        LD_L1_CNT,
        LD_L0_L1
    } load_src_t;

    // one step of the shared 32x32 multiplier, or the xor-shift mix
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_LL,
        MUL_HL,
        MUL_LH,
        MUL_MIX
    } mul_op_t;

    // destination of the diffused value
    typedef enum logic [1:0] {
        WB_NONE,
        WB_L0,
        WB_L1,
        WB_OUT
    } wb_sel_t;

    typedef struct packed {
        logic      capture;
        logic      load;
        load_src_t load_src;
        logic      shift_lanes;
        mul_op_t   mul_op;
        wb_sel_t   wb;
        logic      count_inc;
        logic      reload;
    } dp_cmd_t;

endpackage

[src/two_lane_word_sequence_hash_top.sv]
// ----------------------------------------------------------------------------
// two_lane_word_sequence_hash_top
// two-lane diffusion hash over a stream of 64-bit words
// ----------------------------------------------------------------------------
// usage
//   s_axis: one message word a transaction, tlast on the final word
//   m_axis: one 64-bit hash per message, issued after the final word
//   cfg_wr_en / cfg_wr_data: append_count, write only while idle
// diffusion passes
//   every diffusion pass runs through one shared 32x32 multiplier:
//   load, three partial products, mix, three partial products, write back
//   a word without tlast takes one pass; s_axis_tready stays low until
//   it is done, so the next word waits for the controller to go idle
//   a final word takes d passes to m_axis_tvalid, d = 2, or 3 when
//   append_count is set; the digest pass waits while a hash is pending
// reset
//   aresetn low loads the lane seeds, clears the count, append_count and
//   the output register valid flag
// stall
//   the hash waits in the output register; the next message is absorbed
//   meanwhile and only its own digest waits for m_axis_tready
// ----------------------------------------------------------------------------
module two_lane_word_sequence_hash_top
    import twsh_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // configuration
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,   // append_count
    // input words
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [WORD_W-1:0] s_axis_tdata,  // [63:0] data_word
    input  logic              s_axis_tlast,  // last_word
    // hash results
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [WORD_W-1:0] m_axis_tdata   // [63:0] hash_value
);

    // command bundle from the sequencer to the datapath
    dp_cmd_t dp_cmd;

    twsh_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_axis_tvalid),
        .in_last     (s_axis_tlast),
        .in_ready    (s_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .cmd         (dp_cmd)
    );

    // lanes, counter and the multiplier live here; the hash register drives m_axis
    twsh_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (dp_cmd),
        .in_word  (s_axis_tdata),
        .hash_out (m_axis_tdata)
    );

endmodule

[src/twsh_datapath.sv]
// ----------------------------------------------------------------------------
// twsh_datapath
// lane registers, word counter and a diffusion unit built around one shared
// 32x32 multiplier, stepped by commands from the controller
// ----------------------------------------------------------------------------
module twsh_datapath
    import twsh_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  dp_cmd_t           cmd,
    input  logic [WORD_W-1:0] in_word,
    output logic [WORD_W-1:0] hash_out
);

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] lane0_reg;
    logic [WORD_W-1:0] lane1_reg;
    logic [WORD_W-1:0] v_reg;
    logic [WORD_W-1:0] acc_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [WORD_W-1:0] hash_reg;

    logic [WORD_W-1:0] cnt_word;
    logic [WORD_W-1:0] load_value;
    logic [HALF_W-1:0] mul_a;
    logic [HALF_W-1:0] mul_b;
    logic [WORD_W-1:0] prod;
    logic [HALF_W-1:0] cross_sum;
    logic [HALF_W-1:0] mix_term;

    assign cnt_word = {{(WORD_W-CNT_W){1'b0}}, cnt_reg};

    always_comb begin
        case (cmd.load_src)
            LD_L0_WORD: load_value = lane0_reg ^ word_reg;
            LD_L1_WORD: load_value = lane1_reg ^ word_reg;
            LD_L0_CNT:  load_value = lane0_reg ^ cnt_word;
            LD_L1_CNT:  load_value = lane1_reg ^ cnt_word;
            LD_L0_L1:   load_value = lane0_reg ^ lane1_reg;
            default:    load_value = lane0_reg ^ lane1_reg;
        endcase
    end

    // 64x64 product mod 2^64 from three 32x32 partial products
    assign mul_a     = (cmd.mul_op == MUL_HL) ? v_reg[WORD_W-1:HALF_W] : v_reg[HALF_W-1:0];
    assign mul_b     = (cmd.mul_op == MUL_LH) ? DIFF_MULT[WORD_W-1:HALF_W]
                                              : DIFF_MULT[HALF_W-1:0];
    assign prod      = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};
    assign cross_sum = acc_reg[WORD_W-1:HALF_W] + prod[HALF_W-1:0];
    assign mix_term  = v_reg[WORD_W-1:HALF_W] >> v_reg[WORD_W-1:WORD_W-4];

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            word_reg <= in_word;
        end
        case (cmd.mul_op)
            MUL_LL: begin
                acc_reg <= prod;
            end
            MUL_HL: begin
                acc_reg <= {cross_sum, acc_reg[HALF_W-1:0]};
            end
            MUL_LH: begin
                v_reg <= {cross_sum, acc_reg[HALF_W-1:0]};
            end
            MUL_MIX: begin
                v_reg <= v_reg ^ {{HALF_W{1'b0}}, mix_term};
            end
            default: begin
            end
        endcase
        if (cmd.load) begin
            v_reg <= load_value;
        end
        if (cmd.wb == WB_OUT) begin
            hash_reg <= v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane0_reg <= SEED_LANE0;
            lane1_reg <= SEED_LANE1;
            cnt_reg   <= '0;
        end else begin
            if (cmd.reload) begin
                lane0_reg <= SEED_LANE0;
                lane1_reg <= SEED_LANE1;
                cnt_reg   <= '0;
            end else begin
                if (cmd.shift_lanes) begin
                    lane0_reg <= lane1_reg;
                end
                if (cmd.wb == WB_L0) begin
                    lane0_reg <= v_reg;
                end
                if (cmd.wb == WB_L1) begin
                    lane1_reg <= v_reg;
                end
                if (cmd.count_inc) begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    assign hash_out = hash_reg;

endmodule

[src/twsh_ctrl.sv]
// ----------------------------------------------------------------------------
// twsh_ctrl
// sequencer for the hash: accepts words, schedules one to three diffusion
// passes per word and hands the finished hash to the output register
// ----------------------------------------------------------------------------
module twsh_ctrl
    import twsh_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    cfg_wr_en,
    input  logic    cfg_wr_data,
    input  logic    in_valid,
    input  logic    in_last,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output dp_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MLL,
        ST_MHL,
        ST_MLH,
        ST_MIX,
        ST_WB
    } state_t;

    typedef enum logic [1:0] {
        JOB_PAIRED,
        JOB_FINAL_WORD,
        JOB_FINAL_CNT,
        JOB_DIGEST
    } job_t;

    state_t state_reg, state_next;
    job_t   job_reg, job_next;
    logic   pass_reg, pass_next;
    logic   phase_reg, phase_next;
    logic   last_reg, last_next;
    logic   append_reg, append_next;
    logic   out_valid_reg, out_valid_next;

    logic   accept;
    logic   out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb begin
        cmd             = '0;
        cmd.load_src    = LD_L0_L1;
        cmd.mul_op      = MUL_NONE;
        cmd.wb          = WB_NONE;
        state_next      = state_reg;
        job_next        = job_reg;
        pass_next       = pass_reg;
        phase_next      = phase_reg;
        last_next       = last_reg;
        append_next     = cfg_wr_en ? cfg_wr_data : append_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.capture = 1'b1;
                    last_next   = in_last;
                    job_next    = (in_last && !append_reg) ? JOB_FINAL_WORD : JOB_PAIRED;
                    state_next  = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.load  = 1'b1;
                pass_next = 1'b0;
                case (job_reg)
                    JOB_PAIRED: begin
                        cmd.load_src  = phase_reg ? LD_L1_WORD : LD_L0_WORD;
                        cmd.count_inc = 1'b1;
                    end
                    JOB_FINAL_WORD: begin
                        cmd.load_src    = phase_reg ? LD_L1_WORD : LD_L0_WORD;
                        cmd.shift_lanes = !phase_reg;
                    end
                    JOB_FINAL_CNT: begin
                        cmd.load_src    = phase_reg ? LD_L1_CNT : LD_L0_CNT;
                        cmd.shift_lanes = !phase_reg;
                    end
                    default: begin
                        cmd.load_src = LD_L0_L1;
                    end
                endcase
                state_next = ST_MLL;
            end
            ST_MLL: begin
                cmd.mul_op = MUL_LL;
                state_next = ST_MHL;
            end
            ST_MHL: begin
                cmd.mul_op = MUL_HL;
                state_next = ST_MLH;
            end
            ST_MLH: begin
                cmd.mul_op = MUL_LH;
                state_next = pass_reg ? ST_WB : ST_MIX;
            end
            ST_MIX: begin
                cmd.mul_op = MUL_MIX;
                pass_next  = 1'b1;
                state_next = ST_MLL;
            end
            ST_WB: begin
                case (job_reg)
                    JOB_PAIRED: begin
                        cmd.wb     = phase_reg ? WB_L1 : WB_L0;
                        phase_next = !phase_reg;
                        if (last_reg) begin
                            job_next   = JOB_FINAL_CNT;
                            state_next = ST_LOAD;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                    JOB_FINAL_WORD, JOB_FINAL_CNT: begin
                        cmd.wb     = WB_L1;
                        job_next   = JOB_DIGEST;
                        state_next = ST_LOAD;
                    end
                    default: begin
                        // hold the digest until the output register is free
                        if (out_free) begin
                            cmd.wb         = WB_OUT;
                            cmd.reload     = 1'b1;
                            phase_next     = 1'b0;
                            out_valid_next = 1'b1;
                            state_next     = ST_IDLE;
                        end
                    end
                endcase
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            job_reg       <= JOB_PAIRED;
            pass_reg      <= 1'b0;
            phase_reg     <= 1'b0;
            last_reg      <= 1'b0;
            append_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            job_reg       <= job_next;
            pass_reg      <= pass_next;
            phase_reg     <= phase_next;
            last_reg      <= last_next;
            append_reg    <= append_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    // a pending hash is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wb == WB_OUT) |-> (!out_valid_reg || out_ready))
        else $error("hash register written while a result is pending");

    // an accepted word always starts a diffusion pass
    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_LOAD))
        else $error("accepted word did not start a load");

    // finishing a message leaves the pairing at the first lane
    a_phase_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wb == WB_OUT) |=> (!phase_reg && out_valid_reg))
        else $error("pair phase not cleared after digest");
`endif

endmodule
